### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on i_clk and held off
// while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/dlce_pkg.sv
// ---------------------------------------------------------------------------
// dlce_pkg
// Types, codes and DEFLATE length/distance tables for the copy expander.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlce_pkg;

    localparam int WINDOW_SIZE_DEF      = 32768;
    localparam int BYTES_PER_RESULT_DEF = 8;

    localparam int SYMBOL_W   = 9;
    localparam int LEN_XTRA_W = 5;
    localparam int DCODE_W    = 5;
    localparam int DIST_XTRA_W = 13;
    localparam int LEN_W      = 9;   // 3..258
    localparam int DIST_W     = 16;  // 1..32768
    localparam int OUT_BYTES_W = 64;
    localparam int COUNT_W    = 4;
    localparam int STATUS_W   = 2;

    localparam logic [SYMBOL_W-1:0] SYM_EOB       = 9'd256;
    localparam logic [SYMBOL_W-1:0] SYM_LEN_FIRST = 9'd257;
    localparam logic [SYMBOL_W-1:0] SYM_LEN_END   = 9'd286;
    localparam logic [DCODE_W-1:0]  DCODE_END     = 5'd30;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SYM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_DIST = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FAR      = 2'd3;

    // Symbol classes
    localparam logic [2:0] K_LIT      = 3'd0;
    localparam logic [2:0] K_EOB      = 3'd1;
    localparam logic [2:0] K_BAD_SYM  = 3'd2;
    localparam logic [2:0] K_BAD_DIST = 3'd3;
    localparam logic [2:0] K_COPY     = 3'd4;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        literal;
        logic [LEN_W-1:0]  length;
        logic [DIST_W-1:0] distance;
    } t_dec;

    function automatic logic [LEN_W-1:0] length_base_of(input logic [4:0] li);
        case (li)
            5'd0:  length_base_of = 9'd3;    5'd1:  length_base_of = 9'd4;
            5'd2:  length_base_of = 9'd5;    5'd3:  length_base_of = 9'd6;
            5'd4:  length_base_of = 9'd7;    5'd5:  length_base_of = 9'd8;
            5'd6:  length_base_of = 9'd9;    5'd7:  length_base_of = 9'd10;
            5'd8:  length_base_of = 9'd11;   5'd9:  length_base_of = 9'd13;
            5'd10: length_base_of = 9'd15;   5'd11: length_base_of = 9'd17;
            5'd12: length_base_of = 9'd19;   5'd13: length_base_of = 9'd23;
            5'd14: length_base_of = 9'd27;   5'd15: length_base_of = 9'd31;
            5'd16: length_base_of = 9'd35;   5'd17: length_base_of = 9'd43;
            5'd18: length_base_of = 9'd51;   5'd19: length_base_of = 9'd59;
            5'd20: length_base_of = 9'd67;   5'd21: length_base_of = 9'd83;
            5'd22: length_base_of = 9'd99;   5'd23: length_base_of = 9'd115;
            5'd24: length_base_of = 9'd131;  5'd25: length_base_of = 9'd163;
            5'd26: length_base_of = 9'd195;  5'd27: length_base_of = 9'd227;
            5'd28: length_base_of = 9'd258;
            default: length_base_of = 9'd0;
        endcase
    endfunction

    function automatic logic [2:0] len_bits(input logic [4:0] li);
        case (li)
            5'd8, 5'd9, 5'd10, 5'd11:     len_bits = 3'd1;
            5'd12, 5'd13, 5'd14, 5'd15:   len_bits = 3'd2;
            5'd16, 5'd17, 5'd18, 5'd19:   len_bits = 3'd3;
            5'd20, 5'd21, 5'd22, 5'd23:   len_bits = 3'd4;
            5'd24, 5'd25, 5'd26, 5'd27:   len_bits = 3'd5;
            default:                      len_bits = 3'd0;
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] distance_base_of(input logic [DCODE_W-1:0] dc);
        case (dc)
            5'd0:  distance_base_of = 16'd1;     5'd1:  distance_base_of = 16'd2;
            5'd2:  distance_base_of = 16'd3;     5'd3:  distance_base_of = 16'd4;
            5'd4:  distance_base_of = 16'd5;     5'd5:  distance_base_of = 16'd7;
            5'd6:  distance_base_of = 16'd9;     5'd7:  distance_base_of = 16'd13;
            5'd8:  distance_base_of = 16'd17;    5'd9:  distance_base_of = 16'd25;
            5'd10: distance_base_of = 16'd33;    5'd11: distance_base_of = 16'd49;
            5'd12: distance_base_of = 16'd65;    5'd13: distance_base_of = 16'd97;
            5'd14: distance_base_of = 16'd129;   5'd15: distance_base_of = 16'd193;
            5'd16: distance_base_of = 16'd257;   5'd17: distance_base_of = 16'd385;
            5'd18: distance_base_of = 16'd513;   5'd19: distance_base_of = 16'd769;
            5'd20: distance_base_of = 16'd1025;  5'd21: distance_base_of = 16'd1537;
            5'd22: distance_base_of = 16'd2049;  5'd23: distance_base_of = 16'd3073;
            5'd24: distance_base_of = 16'd4097;  5'd25: distance_base_of = 16'd6145;
            5'd26: distance_base_of = 16'd8193;  5'd27: distance_base_of = 16'd12289;
            5'd28: distance_base_of = 16'd16385; 5'd29: distance_base_of = 16'd24577;
            default: distance_base_of = 16'd0;
        endcase
    endfunction

    // Extra bits: none for codes 0..3, then one more bit every two codes
    function automatic logic [3:0] dist_bits(input logic [DCODE_W-1:0] dc);
        if (dc < 5'd4) begin
            dist_bits = 4'd0;
        end else begin
            dist_bits = 4'(dc[4:1] - 4'd1);
        end
    endfunction

    function automatic logic [12:0] low_mask(input logic [3:0] nbits);
        low_mask = 13'((14'd1 << nbits) - 14'd1);
    endfunction

endpackage

`default_nettype wire

### rtl/dlce_ram.sv
// ---------------------------------------------------------------------------
// dlce_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read and read enable. Read during write returns the old data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dlce_pkg::WINDOW_SIZE_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/dlce_decode.sv
// ---------------------------------------------------------------------------
// dlce_decode
// Classify a literal/length symbol and expand length and distance codes
// through the DEFLATE base and extra-bit tables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlce_decode (
    input  wire logic [dlce_pkg::SYMBOL_W-1:0]    i_symbol,
    input  wire logic [dlce_pkg::LEN_XTRA_W-1:0]  i_length_extra,
    input  wire logic [dlce_pkg::DCODE_W-1:0]     i_distance_code,
    input  wire logic [dlce_pkg::DIST_XTRA_W-1:0] i_distance_extra,
    output dlce_pkg::t_dec                        o_dec
);

    logic [4:0]  li;
    logic [4:0]  lmask;
    logic [12:0] dmask;

    always_comb begin
        li    = 5'(i_symbol - dlce_pkg::SYM_LEN_FIRST);
        lmask = 5'(dlce_pkg::low_mask({1'b0, dlce_pkg::len_bits(li)}));
        dmask = dlce_pkg::low_mask(dlce_pkg::dist_bits(i_distance_code));

        o_dec.literal  = i_symbol[7:0];
        o_dec.length   = dlce_pkg::length_base_of(li)
                       + dlce_pkg::LEN_W'(i_length_extra & lmask);
        o_dec.distance = dlce_pkg::distance_base_of(i_distance_code)
                       + dlce_pkg::DIST_W'(i_distance_extra & dmask);

        if (i_symbol < dlce_pkg::SYM_EOB) begin
            o_dec.kind = dlce_pkg::K_LIT;
        end else if (i_symbol == dlce_pkg::SYM_EOB) begin
            o_dec.kind = dlce_pkg::K_EOB;
        end else if (i_symbol >= dlce_pkg::SYM_LEN_END) begin
            o_dec.kind = dlce_pkg::K_BAD_SYM;
        end else if (i_distance_code >= dlce_pkg::DCODE_END) begin
            o_dec.kind = dlce_pkg::K_BAD_DIST;
        end else begin
            o_dec.kind = dlce_pkg::K_COPY;
        end
    end

endmodule

`default_nettype wire

### rtl/deflate_lz77_copy_expander.sv
// ---------------------------------------------------------------------------
// deflate_lz77_copy_expander
// DEFLATE inflate copy stage: literals, end of block and LZ77 back-reference
// expansion over a history ring held in one synchronous RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) carries one decoded symbol per transaction:
//   tdata = symbol[8:0], length_extra[13:9], distance_code[18:14],
//   distance_extra[31:19]. Master stream (o_m_*) returns result
//   transactions: tdata = out_bytes[63:0], byte_count[67:64],
//   status[69:68]; tuser = end_of_block; tlast marks the final result of
//   the symbol.
//   Literal, end of block, rejected symbols: result to the output register
//   if it is free, else held in S_EMIT. Distance beyond the written history:
//   accept, then the S_SETUP check returns status FAR. Back-reference:
//   accept, distance check, then one history byte per cycle while the
//   receiver does not stall, via the single registered RAM read port. A
//   result leaves every BYTES_PER_RESULT bytes and at the end of the copy.
//   o_s_tready is high only between symbols; a finished result may still
//   wait in the output register while the next symbol is taken.
//   Receiver stall: the output register holds, the copy freezes on the next
//   full word, and one more symbol may be taken, held in S_EMIT until it drains.
//   Reset: pointer and fill count clear; the history RAM is not cleared,
//   the fill-count check keeps unwritten entries from ever being read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module deflate_lz77_copy_expander #(
    parameter int WINDOW_SIZE      = dlce_pkg::WINDOW_SIZE_DEF,
    parameter int BYTES_PER_RESULT = dlce_pkg::BYTES_PER_RESULT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave: symbol, length_extra, distance_code, distance_extra
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,
    // master: out_bytes, byte_count, status, two zero pad bits
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,
    output logic             o_m_tlast,
    // master: end_of_block
    output logic             o_m_tuser
);

    localparam int AW  = $clog2(WINDOW_SIZE);
    localparam int HW  = $clog2(WINDOW_SIZE + 1);
    localparam int NBW = $clog2(BYTES_PER_RESULT + 1);
    localparam int WW  = 8 * BYTES_PER_RESULT;
    localparam int LW  = dlce_pkg::LEN_W;
    localparam int DW  = dlce_pkg::DIST_W;
    localparam int OW  = dlce_pkg::OUT_BYTES_W;
    localparam int CW  = dlce_pkg::COUNT_W;
    localparam int SW  = dlce_pkg::STATUS_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_COPY  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    // control
    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_wp, n_wp;
    logic [HW-1:0] r_held, n_held;
    logic [LW-1:0] r_len, n_len;       // bytes still to store
    logic [LW-1:0] r_issue, n_issue;   // history reads still to issue
    logic          r_dv, n_dv;         // read data valid this cycle
    logic          r_ovalid, n_ovalid;
    // payload
    logic [DW-1:0] r_dist, n_dist;
    logic [AW-1:0] r_rd, n_rd;
    logic [WW-1:0] r_word, n_word;
    logic [NBW-1:0] r_nb, n_nb;
    logic          r_fwd;
    logic [7:0]    r_fwd_data;
    logic [OW-1:0] r_obytes, n_obytes;
    logic [CW-1:0] r_ocount, n_ocount;
    logic          r_oeob, n_oeob;
    logic [SW-1:0] r_ostatus, n_ostatus;
    logic          r_olast, n_olast;
    logic [OW-1:0] r_pbytes, n_pbytes;
    logic [CW-1:0] r_pcount, n_pcount;
    logic          r_peob, n_peob;
    logic [SW-1:0] r_pstatus, n_pstatus;

    dlce_pkg::t_dec dec;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_q;

    logic          accept, slot_free, push;
    logic [OW-1:0] push_bytes;
    logic [CW-1:0] push_count;
    logic          push_eob, push_last;
    logic [SW-1:0] push_status;
    logic [7:0]    cbyte;
    logic [WW-1:0] word_next;
    logic          full, stall;
    logic [16:0]   back_a, back_b;

    dlce_decode u_decode (
        .i_symbol         (i_s_tdata[8:0]),
        .i_length_extra   (i_s_tdata[13:9]),
        .i_distance_code  (i_s_tdata[18:14]),
        .i_distance_extra (i_s_tdata[31:19]),
        .o_dec            (dec)
    );

    dlce_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_ovalid || i_m_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_ostatus, r_ocount, r_obytes};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_oeob;

    // Copy byte: take the write data when the read hit the entry being written
    assign cbyte = r_fwd ? r_fwd_data : ram_q;

    always_comb begin
        for (int i = 0; i < BYTES_PER_RESULT; i++) begin
            word_next[8*i +: 8] = (NBW'(i) == r_nb) ? cbyte : r_word[8*i +: 8];
        end
    end

    assign full  = (r_nb == NBW'(BYTES_PER_RESULT - 1)) || (r_len == LW'(1));
    assign stall = r_dv && full && !slot_free;

    // Back-reference start, wrapped around the ring
    assign back_a = 17'(r_wp) - 17'(r_dist);
    assign back_b = 17'(r_wp) + 17'(WINDOW_SIZE) - 17'(r_dist);

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_held    = r_held;
        n_len     = r_len;
        n_issue   = r_issue;
        n_dv      = r_dv;
        n_dist    = r_dist;
        n_rd      = r_rd;
        n_word    = r_word;
        n_nb      = r_nb;
        n_pbytes  = r_pbytes;
        n_pcount  = r_pcount;
        n_peob    = r_peob;
        n_pstatus = r_pstatus;

        ram_we    = 1'b0;
        ram_waddr = r_wp;
        ram_wdata = cbyte;
        ram_re    = 1'b0;
        ram_raddr = r_rd;

        push        = 1'b0;
        push_bytes  = '0;
        push_count  = '0;
        push_eob    = 1'b0;
        push_status = dlce_pkg::ST_OK;
        push_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (dec.kind == dlce_pkg::K_COPY) begin
                        n_len   = dec.length;
                        n_issue = dec.length;
                        n_dist  = dec.distance;
                        n_state = S_SETUP;
                    end else begin
                        case (dec.kind)
                            dlce_pkg::K_LIT: begin
                                ram_we     = 1'b1;
                                ram_wdata  = dec.literal;
                                push_bytes = OW'(dec.literal);
                                push_count = CW'(1);
                            end
                            dlce_pkg::K_EOB:      push_eob    = 1'b1;
                            dlce_pkg::K_BAD_SYM:  push_status = dlce_pkg::ST_BAD_SYM;
                            default:              push_status = dlce_pkg::ST_BAD_DIST;
                        endcase
                        if (slot_free) begin
                            push = 1'b1;
                        end else begin
                            // hold the result until the output register frees
                            n_pbytes  = push_bytes;
                            n_pcount  = push_count;
                            n_peob    = push_eob;
                            n_pstatus = push_status;
                            n_state   = S_EMIT;
                        end
                    end
                end
            end
            S_SETUP: begin
                if (32'(r_dist) > 32'(r_held)) begin
                    push_status = dlce_pkg::ST_FAR;
                    if (slot_free) begin
                        push    = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        // hold the rejection until the output register frees
                        n_pbytes  = '0;
                        n_pcount  = '0;
                        n_peob    = 1'b0;
                        n_pstatus = dlce_pkg::ST_FAR;
                        n_state   = S_EMIT;
                    end
                end else begin
                    n_rd    = (17'(r_wp) >= 17'(r_dist)) ? AW'(back_a) : AW'(back_b);
                    n_dv    = 1'b0;
                    n_word  = '0;
                    n_nb    = '0;
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                if (!stall) begin
                    if (r_dv) begin
                        ram_we = 1'b1;
                        n_len  = r_len - LW'(1);
                        if (full) begin
                            push       = 1'b1;
                            push_bytes = OW'(word_next);
                            push_count = CW'(r_nb) + CW'(1);
                            push_last  = (r_len == LW'(1));
                            n_word     = '0;
                            n_nb       = '0;
                        end else begin
                            n_word = word_next;
                            n_nb   = r_nb + NBW'(1);
                        end
                        if (r_len == LW'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                    if (r_issue != '0) begin
                        ram_re  = 1'b1;
                        n_rd    = (r_rd == AW'(WINDOW_SIZE - 1)) ? '0 : r_rd + AW'(1);
                        n_issue = r_issue - LW'(1);
                        n_dv    = 1'b1;
                    end else begin
                        n_dv = 1'b0;
                    end
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    push        = 1'b1;
                    push_bytes  = r_pbytes;
                    push_count  = r_pcount;
                    push_eob    = r_peob;
                    push_status = r_pstatus;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Advance the write pointer on every stored byte; the fill count saturates at the window size
        if (ram_we) begin
            n_wp = (r_wp == AW'(WINDOW_SIZE - 1)) ? '0 : r_wp + AW'(1);
            if (r_held != HW'(WINDOW_SIZE)) begin
                n_held = r_held + HW'(1);
            end
        end

        // Output register
        n_ovalid  = r_ovalid && !i_m_tready;
        n_obytes  = r_obytes;
        n_ocount  = r_ocount;
        n_oeob    = r_oeob;
        n_ostatus = r_ostatus;
        n_olast   = r_olast;
        if (push) begin
            n_ovalid  = 1'b1;
            n_obytes  = push_bytes;
            n_ocount  = push_count;
            n_oeob    = push_eob;
            n_ostatus = push_status;
            n_olast   = push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_held   <= '0;
            r_len    <= '0;
            r_issue  <= '0;
            r_dv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_held   <= n_held;
            r_len    <= n_len;
            r_issue  <= n_issue;
            r_dv     <= n_dv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist    <= n_dist;
        r_rd      <= n_rd;
        r_word    <= n_word;
        r_nb      <= n_nb;
        r_obytes  <= n_obytes;
        r_ocount  <= n_ocount;
        r_oeob    <= n_oeob;
        r_ostatus <= n_ostatus;
        r_olast   <= n_olast;
        r_pbytes  <= n_pbytes;
        r_pcount  <= n_pcount;
        r_peob    <= n_peob;
        r_pstatus <= n_pstatus;
        // capture forwarding alongside the registered read
        if (ram_re) begin
            r_fwd      <= ram_we && (ram_waddr == ram_raddr);
            r_fwd_data <= ram_wdata;
        end
    end

    `ASSERT_ALWAYS(a_held_bound, 32'(r_held) <= WINDOW_SIZE, "fill count beyond window")
    `ASSERT_IMPLY(a_copy_balance, r_state == S_COPY,
        10'(r_issue) + 10'(r_dv) == 10'(r_len), "copy read and store counts diverged")
    `ASSERT_IMPLY(a_copy_nonempty, r_state == S_COPY, r_len != '0, "copy with nothing left")
    `ASSERT_IMPLY(a_emit_blocked, r_state == S_EMIT, r_ovalid, "pending result with free slot")

endmodule

`default_nettype wire
